// ===== sv/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, defaults and the result type of the TLB and page-table
// address translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam int ADDR_W   = 16;
    localparam int PAGE_W   = 8;
    localparam int OFFSET_W = 8;
    localparam int CNT_W    = 16;
    localparam int FREE_W   = 9;

    localparam logic [FREE_W-1:0] FREE_MAX = '1;

    localparam int TLB_ENTRIES_DEF  = 16;
    localparam int PAGE_ENTRIES_DEF = 256;

    typedef struct packed {
        logic [ADDR_W-1:0] physical_address;
        logic              tlb_hit;
        logic              table_miss;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  fault_total;
        logic [CNT_W-1:0]  lookup_total;
    } result_t;

endpackage

// ===== sv/tlbpt_ram.sv =====
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/tlbpt_xlate.sv =====
// ----------------------------------------------------------------------------
// tlbpt_xlate
// Lookup engine: reads the TLB and page-table RAMs, resolves hit, table hit
// or fault, writes back the entries and keeps the frame allocator and counts.
// ----------------------------------------------------------------------------
module tlbpt_xlate
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES  = TLB_ENTRIES_DEF,
    parameter int PAGE_ENTRIES = PAGE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [ADDR_W-1:0] logical_address,
    output logic              busy,
    input  logic              res_ready,
    output logic              res_valid,
    output result_t           res
);

    localparam int TLB_AW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int PT_AW  = $clog2(PAGE_ENTRIES);
    localparam int PAGES  = 2 ** PAGE_W;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    state_t                    state_reg;
    state_t                    state_next;
    logic [PAGE_W-1:0]         page_reg;
    logic [OFFSET_W-1:0]       offset_reg;
    logic [TLB_AW-1:0]         slot_reg;
    logic [PT_AW-1:0]          pidx_reg;
    logic [TLB_ENTRIES-1:0]    tlb_valid_reg;
    logic [PAGE_ENTRIES-1:0]   pt_valid_reg;
    logic [FREE_W-1:0]         free_reg;
    logic [FREE_W-1:0]         free_next;
    logic [CNT_W-1:0]          hit_cnt_reg;
    logic [CNT_W-1:0]          hit_cnt_next;
    logic [CNT_W-1:0]          fault_cnt_reg;
    logic [CNT_W-1:0]          fault_cnt_next;
    logic [CNT_W-1:0]          lookup_cnt_reg;
    logic [CNT_W-1:0]          lookup_cnt_next;

    logic [TLB_AW-1:0]         slot_lut [PAGES];
    logic [PT_AW-1:0]          pidx_lut [PAGES];

    logic [PAGE_W-1:0]         in_page;
    logic                      accept;
    logic                      finish;
    logic [2*PAGE_W-1:0]       tlb_rdata;
    logic [PAGE_W-1:0]         pt_rdata;
    logic                      hit;
    logic                      pt_hit;
    logic                      fault;
    logic [PAGE_W-1:0]         frame;
    logic                      tlb_we;
    logic                      pt_we;

    // Slot and table index of every page, folded at elaboration.
    for (genvar g = 0; g < PAGES; g++)
    begin : g_lut
        assign slot_lut[g] = TLB_AW'(g % TLB_ENTRIES);
        assign pidx_lut[g] = PT_AW'(g % PAGE_ENTRIES);
    end

    assign in_page = logical_address[ADDR_W-1 -: PAGE_W];
    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign finish  = (state_reg == ST_LOOKUP) && res_ready;
    assign busy    = (state_reg == ST_LOOKUP);

    tlbpt_ram #(
        .WIDTH (2 * PAGE_W),
        .DEPTH (TLB_ENTRIES)
    ) u_tlb_ram (
        .clk   (clk),
        .we    (tlb_we),
        .waddr (slot_reg),
        .wdata ({page_reg, frame}),
        .re    (accept),
        .raddr (slot_lut[in_page]),
        .rdata (tlb_rdata)
    );

    tlbpt_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (PAGE_ENTRIES)
    ) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pidx_reg),
        .wdata (frame),
        .re    (accept),
        .raddr (pidx_lut[in_page]),
        .rdata (pt_rdata)
    );

    always_comb
    begin
        hit    = tlb_valid_reg[slot_reg] && (tlb_rdata[2*PAGE_W-1:PAGE_W] == page_reg);
        pt_hit = pt_valid_reg[pidx_reg];
        fault  = !hit && !pt_hit;

        if (hit)
        begin
            frame = tlb_rdata[PAGE_W-1:0];
        end
        else if (pt_hit)
        begin
            frame = pt_rdata;
        end
        else
        begin
            frame = free_reg[PAGE_W-1:0];
        end

        tlb_we = finish && !hit;
        pt_we  = finish && fault;

        free_next       = (fault && (free_reg != FREE_MAX)) ? free_reg + 1'b1 : free_reg;
        hit_cnt_next    = hit ? sat_inc(hit_cnt_reg) : hit_cnt_reg;
        fault_cnt_next  = fault ? sat_inc(fault_cnt_reg) : fault_cnt_reg;
        lookup_cnt_next = sat_inc(lookup_cnt_reg);

        unique case (state_reg)
            ST_IDLE:   state_next = accept ? ST_LOOKUP : ST_IDLE;
            ST_LOOKUP: state_next = finish ? ST_IDLE : ST_LOOKUP;
            default:   state_next = ST_IDLE;
        endcase

        res_valid            = (state_reg == ST_LOOKUP);
        res.physical_address = {frame, offset_reg};
        res.tlb_hit          = hit;
        res.table_miss       = fault;
        res.hit_total        = hit_cnt_next;
        res.fault_total      = fault_cnt_next;
        res.lookup_total     = lookup_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tlb_valid_reg  <= '0;
            pt_valid_reg   <= '0;
            free_reg       <= '0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            lookup_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                free_reg       <= free_next;
                hit_cnt_reg    <= hit_cnt_next;
                fault_cnt_reg  <= fault_cnt_next;
                lookup_cnt_reg <= lookup_cnt_next;
            end
            if (tlb_we)
            begin
                tlb_valid_reg[slot_reg] <= 1'b1;
            end
            if (pt_we)
            begin
                pt_valid_reg[pidx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg   <= in_page;
            offset_reg <= logical_address[OFFSET_W-1:0];
            slot_reg   <= slot_lut[in_page];
            pidx_reg   <= pidx_lut[in_page];
        end
    end

endmodule

// ===== sv/tlb_page_table_translator_top.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translator_top
// Address translator with a direct-mapped TLB, a single-level page table and
// an up-counting frame allocator.
// ----------------------------------------------------------------------------
// Each accepted word carries a 16-bit logical address: the upper byte is the
// page and the lower byte the offset. The page is looked up in a direct-mapped
// TLB at slot page mod TLB_ENTRIES; on a miss the page table is consulted at
// index page mod PAGE_ENTRIES, and on a page-table miss the next free frame
// is allocated and written into both tables. One result word follows every
// input word, giving the physical address, the hit and fault flags and
// saturating running counts. Acceptance starts the registered read of both
// table RAMs; the lookup state then resolves the lookup, presents the result
// and, once it is taken, writes back the TLB slot and page-table entry. The
// input stays stalled for the whole lookup, so a new word is taken only after
// the previous result has been handed on. Results land in an output register,
// so a new word is taken while the previous result waits downstream; a
// resolved lookup waits while that register is still held. Valid bits live in
// flip-flops cleared by reset, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_top
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES  = TLB_ENTRIES_DEF,
    parameter int PAGE_ENTRIES = PAGE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ADDR_W-1:0] logical_address,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] physical_address,
    output logic              tlb_hit,
    output logic              table_miss,
    output logic [CNT_W-1:0]  hit_total,
    output logic [CNT_W-1:0]  fault_total,
    output logic [CNT_W-1:0]  lookup_total
);

    logic    res_ready;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    // The lookup engine holds one item at a time and stalls the input while
    // it is working on it.
    tlbpt_xlate #(
        .TLB_ENTRIES  (TLB_ENTRIES),
        .PAGE_ENTRIES (PAGE_ENTRIES)
    ) u_xlate (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .logical_address (logical_address),
        .busy            (in_stall),
        .res_ready       (res_ready),
        .res_valid       (res_valid),
        .res             (res)
    );

    // The output register may be loaded when it is empty or being emptied.
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign physical_address = out_reg.physical_address;
    assign tlb_hit          = out_reg.tlb_hit;
    assign table_miss       = out_reg.table_miss;
    assign hit_total        = out_reg.hit_total;
    assign fault_total      = out_reg.fault_total;
    assign lookup_total     = out_reg.lookup_total;

endmodule

// ===== sv/tlbpt_checker.sv =====
// ----------------------------------------------------------------------------
// tlbpt_props
// Port-level checks on the address translator, bound to the top level.
// ----------------------------------------------------------------------------
module tlbpt_props
    import tlbpt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [ADDR_W-1:0] physical_address,
    input logic              tlb_hit,
    input logic              table_miss,
    input logic [CNT_W-1:0]  fault_total,
    input logic [CNT_W-1:0]  lookup_total
);

    // An accepted word keeps the engine busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on two consecutive cycles");

    // A held result word stays valid and keeps its physical address.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(physical_address))
        else $error("stalled result word changed");

    // A TLB hit can never also be a page fault.
    a_hit_not_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tlb_hit && table_miss))
        else $error("result flags both hit and fault");

    // Every result has been counted, and a fault is counted too.
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lookup_total != '0) && (!table_miss || (fault_total != '0)))
        else $error("running counts miss the current word");

endmodule

bind tlb_page_table_translator_top tlbpt_props u_tlbpt_props (.*);

// ===== tb/tlbpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_checker
// Watches both channels of the address translator, predicts each result word
// from its own copy of the TLB, page table and counters, and compares.
// ----------------------------------------------------------------------------
module tlbpt_checker
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES  = TLB_ENTRIES_DEF,
    parameter int PAGE_ENTRIES = PAGE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [ADDR_W-1:0] logical_address,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [ADDR_W-1:0] physical_address,
    input  logic              tlb_hit,
    input  logic              table_miss,
    input  logic [CNT_W-1:0]  hit_total,
    input  logic [CNT_W-1:0]  fault_total,
    input  logic [CNT_W-1:0]  lookup_total,
    output int                outstanding,
    output int                failures
);

    logic [PAGE_W-1:0] tlb_tag_q   [TLB_ENTRIES];
    logic [PAGE_W-1:0] tlb_frame_q [TLB_ENTRIES];
    logic              tlb_valid_q [TLB_ENTRIES];
    logic [PAGE_W-1:0] pt_frame_q  [PAGE_ENTRIES];
    logic              pt_valid_q  [PAGE_ENTRIES];
    logic [FREE_W-1:0] free_frame_q;
    logic [CNT_W-1:0]  hits_q;
    logic [CNT_W-1:0]  faults_q;
    logic [CNT_W-1:0]  lookups_q;

    result_t expected_translations[$];
    int      fail_tally = 0;

    // Advances the translator state by one address and returns its result.
    function automatic result_t translate_address(input logic [ADDR_W-1:0] addr);
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        logic [PAGE_W-1:0]   frame;
        int                  slot;
        int                  pidx;
        result_t             res;
        page   = addr[ADDR_W-1:OFFSET_W];
        offset = addr[OFFSET_W-1:0];
        slot   = int'(page) % TLB_ENTRIES;
        pidx   = int'(page) % PAGE_ENTRIES;
        res    = '0;
        if (lookups_q != '1)
            lookups_q++;
        if (tlb_valid_q[slot] && tlb_tag_q[slot] == page) begin
            res.tlb_hit = 1'b1;
            frame = tlb_frame_q[slot];
            if (hits_q != '1)
                hits_q++;
        end
        else begin
            if (pt_valid_q[pidx]) begin
                frame = pt_frame_q[pidx];
            end
            else begin
                res.table_miss = 1'b1;
                frame = free_frame_q[PAGE_W-1:0];
                if (free_frame_q != FREE_MAX)
                    free_frame_q++;
                pt_frame_q[pidx] = frame;
                pt_valid_q[pidx] = 1'b1;
                if (faults_q != '1)
                    faults_q++;
            end
            tlb_tag_q[slot]   = page;
            tlb_frame_q[slot] = frame;
            tlb_valid_q[slot] = 1'b1;
        end
        res.physical_address = {frame, offset};
        res.hit_total        = hits_q;
        res.fault_total      = faults_q;
        res.lookup_total     = lookups_q;
        return res;
    endfunction

    task automatic check_field(input string field_name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field_name, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            for (int i = 0; i < TLB_ENTRIES; i++)
                tlb_valid_q[i] = 1'b0;
            for (int i = 0; i < PAGE_ENTRIES; i++)
                pt_valid_q[i] = 1'b0;
            free_frame_q = '0;
            hits_q       = '0;
            faults_q     = '0;
            lookups_q    = '0;
            expected_translations.delete();
        end
        else begin
            // The result word is taken before the input word of the same edge,
            // since it can never belong to that input.
            if (out_valid && !out_stall) begin
                if (expected_translations.size() == 0) begin
                    $error("result word with no expectation waiting: physical_address %0d",
                           physical_address);
                    fail_tally++;
                end
                else begin
                    want = expected_translations.pop_front();
                    check_field("physical_address", want.physical_address, physical_address);
                    check_field("tlb_hit", want.tlb_hit, tlb_hit);
                    check_field("table_miss", want.table_miss, table_miss);
                    check_field("hit_total", want.hit_total, hit_total);
                    check_field("fault_total", want.fault_total, fault_total);
                    check_field("lookup_total", want.lookup_total, lookup_total);
                end
            end
            if (in_valid && !in_stall)
                expected_translations.push_back(translate_address(logical_address));
        end
        outstanding <= expected_translations.size();
        failures    <= fail_tally;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the TLB and page-table address translator.
// ----------------------------------------------------------------------------
// A short directed run touches the extreme offsets and pages, TLB conflicts
// within one slot and page-table hits after eviction. Random phases follow,
// mostly reusing recent pages and their slot neighbours so that hits, conflict
// misses and faults all occur often. A sweep of every page then fills the
// whole page table so that every frame is handed out. The checker beside the
// block does all prediction and comparison; this module only drives words
// and decides.
// ----------------------------------------------------------------------------
module tb_top;
    import tlbpt_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [ADDR_W-1:0] logical_address = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ADDR_W-1:0] physical_address;
    logic              tlb_hit;
    logic              table_miss;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  fault_total;
    logic [CNT_W-1:0]  lookup_total;

    int outstanding;
    int failures;

    // Idling rates in per cent, and a request for a long receiver hold-off.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;

    // Pages seen lately; reusing them makes TLB hits and slot conflicts common.
    logic [PAGE_W-1:0] recent_pages[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tlb_page_table_translator_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .logical_address  (logical_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .table_miss       (table_miss),
        .hit_total        (hit_total),
        .fault_total      (fault_total),
        .lookup_total     (lookup_total)
    );

    tlbpt_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .logical_address  (logical_address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .table_miss       (table_miss),
        .hit_total        (hit_total),
        .fault_total      (fault_total),
        .lookup_total     (lookup_total),
        .outstanding      (outstanding),
        .failures         (failures)
    );

    // Receiver: random stalls, or a long hold-off counted out here so that the
    // block fills up and stalls its input while the sender keeps offering.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
            end
        end
    end

    // Offers one word, possibly after some idle cycles, and returns at the edge
    // that accepts it. Valid is left high so that back-to-back words are not
    // lowered and raised again within one step.
    task automatic offer_address(input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        logical_address <= addr;
        do
            @(posedge clk);
        while (in_stall);
        recent_pages.push_back(addr[ADDR_W-1:OFFSET_W]);
        if (recent_pages.size() > 8)
            void'(recent_pages.pop_front());
    endtask

    // Stops offering and waits until every expected result word has arrived.
    // The extra edge lets the word just accepted be counted as outstanding.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Random addresses: mostly recent pages (hits) and pages sharing a slot with
    // a recent one (conflict misses, often page-table hits), the rest anywhere.
    task automatic run_random(input int count, input bit with_hold, input bit with_pause);
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        int                  pick;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 && with_hold)
                hold_request = 80;
            if (i == count / 2 && with_pause)
                drain_results();
            pick   = $urandom_range(99, 0);
            offset = OFFSET_W'($urandom_range(255, 0));
            page   = PAGE_W'($urandom_range(255, 0));
            if (recent_pages.size() != 0 && pick < 45)
            begin
                page = recent_pages[$urandom_range(recent_pages.size() - 1, 0)];
            end
            else if (recent_pages.size() != 0 && pick < 70)
            begin
                page = recent_pages[$urandom_range(recent_pages.size() - 1, 0)];
                page[PAGE_W-1:4] = page[PAGE_W-1:4] ^ 4'($urandom_range(15, 1));
            end
            offer_address({page, offset});
        end
    endtask

    initial
    begin
        static logic [ADDR_W-1:0] directed_addresses [19] = '{
            16'h0000,   // first fault, frame zero
            16'h00FF,   // TLB hit, highest offset
            16'hFFFF,   // highest page, last slot
            16'hFF00,   // hit, lowest offset
            16'h0F80,   // evicts page 255 from its slot
            16'hFF7F,   // evicted page: TLB miss, page-table hit
            16'h0F01,   // and back again
            16'h8000,   // evicts page 0 from slot 0
            16'h0055,
            16'h5AA5, 16'hA55A, 16'h5A00, 16'hA5FF,
            16'h7F7F, 16'h8080, 16'h7FFF, 16'h8001,
            16'h1000,   // third page in slot 0
            16'h0000
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles more lightly than the receiver first.
        send_idle_pct = 35;
        recv_idle_pct = 48;
        foreach (directed_addresses[i])
            offer_address(directed_addresses[i]);
        run_random(95, 1'b1, 1'b0);

        // Then the other way round, with a pause until everything has drained.
        send_idle_pct = 48;
        recv_idle_pct = 35;
        run_random(95, 1'b0, 1'b1);

        // Neither side idles from here on.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(85, 1'b0, 1'b0);

        // Every page once, so the page table fills and all frames are handed out.
        for (int p = 0; p < 256; p++)
            offer_address({PAGE_W'(p), OFFSET_W'($urandom_range(255, 0))});

        drain_results();
        repeat (4) @(posedge clk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // A run that has not finished in time is reported as failed.
    initial
    begin
        #400_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tlbpt_pkg.sv
sv/tlbpt_ram.sv
sv/tlbpt_xlate.sv
sv/tlb_page_table_translator_top.sv
sv/tlbpt_checker.sv
tb/tlbpt_checker.sv
tb/tb_top.sv
